### rtl/tun_pkg.sv
`default_nettype none
package tun_pkg;

    // Coordinate and result widths are fixed by the word formats below.
    localparam int CW  = 16;          // vertex coordinate width
    localparam int EW  = CW + 1;      // edge vector component width
    localparam int PRW = 2 * EW;      // one partial product of the cross product
    localparam int PW  = PRW + 1;     // cross product component, signed
    localparam int MW  = PW;          // magnitude of a cross product component
    localparam int SHW = $clog2(MW);  // normalising shift amount
    localparam int UW  = 30;          // magnitude after the normalising shift
    localparam int SQW = 2 * UW + 2;  // sum of three squares
    localparam int RTW = UW + 1;      // integer square root
    localparam int OW  = 16;          // result component width

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
    } t_in_word;

    typedef struct packed {
        logic signed [OW-1:0] nx;
        logic signed [OW-1:0] ny;
        logic signed [OW-1:0] nz;
        logic                 degenerate;
    } t_out_word;

    // Per-item data that rides alongside the square root pipeline.
    typedef struct packed {
        logic [2:0][UW-1:0] u;
        logic [2:0]         neg;
        logic               deg;
    } t_side;

endpackage
`default_nettype wire

### rtl/tun_div_lane.sv
`default_nettype none
// Pipelined restoring divider for one component: round(u * 2^FRAC / len),
// saturated at one and signed. One quotient bit per stage.
module tun_div_lane #(
    parameter int FRAC = 14
) (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire [tun_pkg::UW-1:0]            i_u,
    input  wire [tun_pkg::RTW-1:0]           i_len,
    input  wire                              i_neg,
    output logic signed [tun_pkg::OW-1:0]    o_q
);

    localparam int QW  = FRAC + 1;
    localparam int RW  = tun_pkg::RTW + 1;

    logic [RW-1:0] r_rm [0:QW];
    logic [QW-1:0] r_lo [0:QW];
    logic [RW-1:0] r_dv [0:QW];
    logic [QW-1:0] r_q  [0:QW];
    logic          r_ng [0:QW];

    // Dividend is (u << (FRAC+1)) + len, divisor 2*len: split off the top.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rm[0] <= RW'(i_u) + RW'(i_len >> QW);
            r_lo[0] <= i_len[QW-1:0];
            r_dv[0] <= {i_len, 1'b0};
            r_q[0]  <= '0;
            r_ng[0] <= i_neg;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
        logic [RW:0]   sh;
        logic [RW:0]   df;
        logic          qb;
        always_comb begin
            sh = {r_rm[j-1], r_lo[j-1][QW-j]};
            df = sh - {1'b0, r_dv[j-1]};
            qb = (sh >= {1'b0, r_dv[j-1]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[j] <= qb ? df[RW-1:0] : sh[RW-1:0];
                r_lo[j] <= r_lo[j-1];
                r_dv[j] <= r_dv[j-1];
                r_q[j]  <= {r_q[j-1][QW-2:0], qb};
                r_ng[j] <= r_ng[j-1];
            end
        end
    end

    logic [QW-1:0] sat;
    logic [63:0]   mag64;
    logic [63:0]   val64;
    always_comb begin
        sat   = (r_q[QW] > QW'(1) << FRAC) ? (QW'(1) << FRAC) : r_q[QW];
        mag64 = 64'(sat);
        val64 = r_ng[QW] ? (64'd0 - mag64) : mag64;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= val64[tun_pkg::OW-1:0];
        end
    end

endmodule
`default_nettype wire

### rtl/triangle_unit_normal_core.sv
`default_nettype none
// Triangle unit normal. Each input word carries three vertices A, B, C as
// signed 16-bit coordinates; each output word carries the unit normal of
// (B-A) x (C-A) in signed Q1.NORMAL_FRAC_BITS (round to nearest, ties away
// from zero, saturated at one) and a degenerate flag, set with a zero normal
// when the cross product vanishes. The block is a fully pipelined datapath: a
// new word is taken every cycle unless the pipeline holds, and each word goes
// through the 31-stage square root, one root bit per stage, and the divider,
// one quotient bit per stage. Words flow in order, one result per input word.
// The whole pipeline holds when a finished word waits at the output and the
// output is not taken; the input is ready whenever the output register is
// empty or is being read.
module triangle_unit_normal_core #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tun_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tun_pkg::t_out_word   o_out_word
);

    localparam int EW  = tun_pkg::EW;
    localparam int PRW = tun_pkg::PRW;
    localparam int PW  = tun_pkg::PW;
    localparam int MW  = tun_pkg::MW;
    localparam int SHW = tun_pkg::SHW;
    localparam int UW  = tun_pkg::UW;
    localparam int SQW = tun_pkg::SQW;
    localparam int RTW = tun_pkg::RTW;
    localparam int DL  = NORMAL_FRAC_BITS + 3;   // divider latency
    localparam int NS  = 8 + RTW + DL;           // total stages

    logic en;
    logic r_v [1:NS];

    // Advance every stage together; hold all when the output word is stuck.
    assign en          = !r_v[NS] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_v[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[1] <= i_in_valid;
            for (int k = 2; k <= NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Stage 1: edge vectors E1 = B - A, E2 = C - A.
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1[0] <= EW'(i_in_word.bx) - EW'(i_in_word.ax);
            r_e1[1] <= EW'(i_in_word.by) - EW'(i_in_word.ay);
            r_e1[2] <= EW'(i_in_word.bz) - EW'(i_in_word.az);
            r_e2[0] <= EW'(i_in_word.cx) - EW'(i_in_word.ax);
            r_e2[1] <= EW'(i_in_word.cy) - EW'(i_in_word.ay);
            r_e2[2] <= EW'(i_in_word.cz) - EW'(i_in_word.az);
        end
    end

    // Stage 2: the six partial products of the cross product.
    logic signed [PRW-1:0] r_pp [6];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp[0] <= r_e1[1] * r_e2[2];
            r_pp[1] <= r_e1[2] * r_e2[1];
            r_pp[2] <= r_e1[2] * r_e2[0];
            r_pp[3] <= r_e1[0] * r_e2[2];
            r_pp[4] <= r_e1[0] * r_e2[1];
            r_pp[5] <= r_e1[1] * r_e2[0];
        end
    end

    // Stage 3: cross product components.
    logic signed [PW-1:0] r_p [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= PW'(r_pp[2*i]) - PW'(r_pp[2*i+1]);
            end
        end
    end

    // Stage 4: magnitudes, signs and the degenerate test.
    logic [MW-1:0] r_m4 [3];
    logic [2:0]    r_ng4;
    logic          r_dg4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ng4[i] <= r_p[i][PW-1];
                r_m4[i]  <= r_p[i][PW-1] ? MW'(-r_p[i]) : MW'(r_p[i]);
            end
            r_dg4 <= (r_p[0] == '0) && (r_p[1] == '0) && (r_p[2] == '0);
        end
    end

    // Stage 5: normalising shift from the leading one of the largest magnitude.
    logic [MW-1:0]  orv;
    logic [SHW-1:0] msb;
    logic [SHW-1:0] sh5;
    always_comb begin
        orv = r_m4[0] | r_m4[1] | r_m4[2];
        msb = '0;
        for (int b = 0; b < MW; b++) begin
            if (orv[b]) msb = SHW'(b);
        end
        sh5 = (int'(msb) > UW - 1) ? SHW'(int'(msb) - (UW - 1)) : '0;
    end

    logic [MW-1:0]  r_m5 [3];
    logic [SHW-1:0] r_sh5;
    logic [2:0]     r_ng5;
    logic           r_dg5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m5  <= r_m4;
            r_sh5 <= sh5;
            r_ng5 <= r_ng4;
            r_dg5 <= r_dg4;
        end
    end

    // Stage 6: truncate the magnitudes into the square root's range.
    tun_pkg::t_side r_sd6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sd6.u[i] <= UW'(r_m5[i] >> r_sh5);
            end
            r_sd6.neg <= r_ng5;
            r_sd6.deg <= r_dg5;
        end
    end

    // Stage 7: squares.
    logic [2*UW-1:0] r_sq [3];
    tun_pkg::t_side  r_sd7;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_sd6.u[i] * r_sd6.u[i];
            end
            r_sd7 <= r_sd6;
        end
    end

    // Stage 8 loads the square root pipeline with the sum of squares.
    logic [SQW-1:0]   r_sx [0:RTW];
    logic [RTW-1:0]   r_rt [0:RTW];
    logic [RTW+1:0]   r_rm [0:RTW];
    tun_pkg::t_side   r_sd [0:RTW];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx[0] <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
            r_rt[0] <= '0;
            r_rm[0] <= '0;
            r_sd[0] <= r_sd7;
        end
    end

    // Square root: bring down two radicand bits, settle one root bit a stage.
    for (genvar k = 1; k <= RTW; k++) begin : g_sqrt
        logic [RTW+3:0] rsh;
        logic [RTW+3:0] trial;
        logic           take;
        always_comb begin
            rsh   = {r_rm[k-1], r_sx[k-1][SQW-1:SQW-2]};
            trial = (RTW+4)'({r_rt[k-1], 2'b01});
            take  = (rsh >= trial);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sx[k] <= {r_sx[k-1][SQW-3:0], 2'b00};
                r_rm[k] <= take ? (RTW+2)'(rsh - trial) : (RTW+2)'(rsh);
                r_rt[k] <= {r_rt[k-1][RTW-2:0], take};
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Division lanes, one per component.
    logic signed [tun_pkg::OW-1:0] q [3];
    for (genvar i = 0; i < 3; i++) begin : g_lane
        tun_div_lane #(
            .FRAC (NORMAL_FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_u   (r_sd[RTW].u[i]),
            .i_len (r_rt[RTW]),
            .i_neg (r_sd[RTW].neg[i]),
            .o_q   (q[i])
        );
    end

    // Carry the degenerate flag alongside the divider.
    logic r_dg [1:DL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dg[1] <= r_sd[RTW].deg;
            for (int k = 2; k <= DL; k++) r_dg[k] <= r_dg[k-1];
        end
    end

    // Drop the quotients of a degenerate word: its length is zero.
    always_comb begin
        o_out_word.nx         = r_dg[DL] ? '0 : q[0];
        o_out_word.ny         = r_dg[DL] ? '0 : q[1];
        o_out_word.nz         = r_dg[DL] ? '0 : q[2];
        o_out_word.degenerate = r_dg[DL];
    end

endmodule
`default_nettype wire
